### src/drum_step_sequencer_defines.svh
// Assertion macros shared by the drum step sequencer RTL.
// Depends on a clk and an active-low rst_n in the scope of each use.
`ifndef DRUM_STEP_SEQUENCER_DEFINES_SVH
`define DRUM_STEP_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DSS_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("drum_step_sequencer: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DSS_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("drum_step_sequencer: next-cycle check failed");

`endif

### src/dss_pkg.sv
// Shared types, constants and the pad decoder of the drum step sequencer.
// No dependencies; every other file but the defines header imports this package.
package dss_pkg;

    localparam int CHANNELS = 16;
    localparam int STEPS    = 32;
    localparam int CH_W     = $clog2(CHANNELS);
    localparam int STEP_W   = $clog2(STEPS);
    localparam int VEL_W    = 7;
    localparam int NOTE_W   = 7;
    localparam int PAD_W    = 7;

    localparam logic [VEL_W-1:0]  QUANT_LEVEL = 7'd100;
    localparam logic [NOTE_W-1:0] OFFSET_MAX  = 7'd112;
    localparam logic [NOTE_W-1:0] LIVE_BASE   = 7'd36;

    localparam logic [7:0]       TICK_PERIOD_RST = 8'd200;
    localparam logic [7:0]       TICK_COUNT_RST  = 8'd200;
    localparam logic [6:0]       NOTE_OFFSET_RST = 7'd36;
    localparam logic [PAD_W-1:0] QUANT_BTN_RST   = 7'd40;
    localparam logic [PAD_W-1:0] DEL_BTN_RST     = 7'd50;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTE_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANT_BTN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEL_BTN     = 2'd3;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_PAD  = 1'b1;

    // One memory row holds the velocities of all channels at one step.
    typedef logic [CHANNELS-1:0][VEL_W-1:0] pattern_row_t;

    typedef struct packed {
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  note_velocity;
        logic              live;
        logic              last;
    } note_beat_t;

    typedef struct packed {
        logic [3:0] row;
        logic [3:0] col;
    } pad_pos_t;

    // Splits a pad number into row and column by comparing against the
    // multiples of ten rather than dividing.
    function automatic pad_pos_t pad_decode(input logic [PAD_W-1:0] idx);
        pad_pos_t   p;
        logic [3:0] r;
        r = 4'd0;
        for (int k = 1; k <= 12; k++)
        begin
            if (idx >= PAD_W'(k * 10))
                r = 4'(k);
        end
        p.row = r;
        p.col = 4'(idx - PAD_W'(r * 10));
        return p;
    endfunction

endpackage

### src/dss_ifs.sv
// Valid/ready channel interfaces of the drum step sequencer: events in,
// notes out and the configuration write channel. Depends on dss_pkg.
interface dss_event_if;
    import dss_pkg::*;
    logic             valid;
    logic             ready;
    logic             command;
    logic [PAD_W-1:0] pad_index;
    logic [VEL_W-1:0] velocity;
    modport source (output valid, command, pad_index, velocity, input ready);
    modport sink (input valid, command, pad_index, velocity, output ready);
endinterface

interface dss_note_if;
    import dss_pkg::*;
    logic              valid;
    logic              ready;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  note_velocity;
    logic              live;
    logic              last;
    modport source (output valid, note, note_velocity, live, last, input ready);
    modport sink (input valid, note, note_velocity, live, last, output ready);
endinterface

interface dss_cfg_if;
    import dss_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### src/dss_pattern_mem.sv
// Pattern memory: one row per step, one lane per channel, registered read.
// Depends on dss_pkg. Per-row valid flags stand in for a clear at reset.
module dss_pattern_mem (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      rd_en,
    input  logic [dss_pkg::STEP_W-1:0] rd_addr,
    output dss_pkg::pattern_row_t     rd_data,
    input  logic                      wr_en,
    input  logic [dss_pkg::STEP_W-1:0] wr_addr,
    input  dss_pkg::pattern_row_t     wr_data
);
    import dss_pkg::*;

    pattern_row_t       mem [STEPS];
    pattern_row_t       rd_raw_reg;
    logic               rd_valid_reg;
    logic [STEPS-1:0]   row_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_raw_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
                row_valid_reg[wr_addr] <= 1'b1;
            if (rd_en)
                rd_valid_reg <= row_valid_reg[rd_addr];
        end
    end

    // A row never written since reset reads as all zeros.
    assign rd_data = rd_valid_reg ? rd_raw_reg : '0;

endmodule

### src/dss_out_reg.sv
// Output register of the note channel: holds one beat until it is taken.
// Depends on dss_pkg and dss_ifs.
module dss_out_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  dss_pkg::note_beat_t beat,
    output logic                slot_free,
    dss_note_if.source          notes
);
    import dss_pkg::*;

    logic       valid_reg;
    note_beat_t beat_reg;

    assign slot_free = !valid_reg || notes.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (notes.ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            beat_reg <= beat;
    end

    assign notes.valid         = valid_reg;
    assign notes.note          = beat_reg.note;
    assign notes.note_velocity = beat_reg.note_velocity;
    assign notes.live          = beat_reg.live;
    assign notes.last          = beat_reg.last;

endmodule

### src/drum_step_sequencer.sv
// Top level of the drum step sequencer: control sequencer, configuration
// registers, pattern memory and note output register.
// Depends on dss_pkg, dss_ifs, dss_pattern_mem, dss_out_reg and the defines.
`include "drum_step_sequencer_defines.svh"

// The block takes one event at a time. A tick that does not advance the
// step, a channel select and an ignored pad are handled in the idle state. A
// tick that advances reads the step's row from the pattern memory and then
// checks one channel per cycle, stalling while the note sink holds off a
// sounding channel. A step toggle is a read-modify-write of one row; a live
// note waits for the output slot. Quantize and clear sweep all 32 rows
// through the memory's read and write ports, reading one row while writing
// back the previous. The pattern memory needs no clearing pass after reset:
// a flag per row marks rows that were never written, and they read as zero.
// The configuration channel is always ready.
module drum_step_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    dss_cfg_if.sink     cfg,
    dss_event_if.sink   events,
    dss_note_if.source  notes
);
    import dss_pkg::*;

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_TICK_RD   = 3'd1;
    localparam logic [2:0] ST_TICK_SCAN = 3'd2;
    localparam logic [2:0] ST_STEP_RD   = 3'd3;
    localparam logic [2:0] ST_STEP_WR   = 3'd4;
    localparam logic [2:0] ST_LIVE      = 3'd5;
    localparam logic [2:0] ST_SWEEP     = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [7:0]        tick_period_reg;
    logic [6:0]        note_offset_reg;
    logic [PAD_W-1:0]  quant_btn_reg;
    logic [PAD_W-1:0]  del_btn_reg;
    logic [7:0]        tick_count_reg, tick_count_next;
    logic [STEP_W-1:0] play_pos_reg, play_pos_next;
    logic [CH_W-1:0]   sel_ch_reg, sel_ch_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [VEL_W-1:0]  vel_reg, vel_next;
    logic [NOTE_W-1:0] live_note_reg, live_note_next;
    logic              quant_mode_reg, quant_mode_next;
    logic [CH_W-1:0]   scan_ch_reg, scan_ch_next;
    logic [STEP_W:0]   sweep_cnt_reg, sweep_cnt_next;

    logic              accept;
    logic [7:0]        tick_inc;
    logic              tick_fire;
    pad_pos_t          pos;
    logic [3:0]        row_inv8, row_inv4, col_m5, col_m1;
    logic              press;
    logic              is_step, is_live, is_chan;
    logic [NOTE_W-1:0] offset_clamped;

    logic              mem_rd_en, mem_wr_en;
    logic [STEP_W-1:0] mem_rd_addr, mem_wr_addr;
    pattern_row_t      mem_rd_data, mem_wr_data;

    logic [CHANNELS-1:0] lane_nz;
    logic [CHANNELS-1:0] nz_above;
    logic [VEL_W-1:0]    scan_vel;
    logic [VEL_W-1:0]    sel_vel;

    logic              out_load;
    logic              out_free;
    note_beat_t        out_beat;

    // ---------------- configuration ----------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_period_reg <= TICK_PERIOD_RST;
            note_offset_reg <= NOTE_OFFSET_RST;
            quant_btn_reg   <= QUANT_BTN_RST;
            del_btn_reg     <= DEL_BTN_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_TICK_PERIOD: tick_period_reg <= cfg.data;
                CFG_NOTE_OFFSET: note_offset_reg <= cfg.data[6:0];
                CFG_QUANT_BTN:   quant_btn_reg   <= cfg.data[PAD_W-1:0];
                CFG_DEL_BTN:     del_btn_reg     <= cfg.data[PAD_W-1:0];
            endcase
        end
    end

    assign offset_clamped = (note_offset_reg > OFFSET_MAX) ? OFFSET_MAX : note_offset_reg;

    // ---------------- event decode ----------------
    assign events.ready = (state_reg == ST_IDLE);
    assign accept       = events.valid && events.ready;

    assign tick_inc  = tick_count_reg + 8'd1;
    assign tick_fire = (tick_inc >= tick_period_reg);

    assign pos      = pad_decode(events.pad_index);
    assign row_inv8 = 4'd8 - pos.row;
    assign row_inv4 = 4'd4 - pos.row;
    assign col_m5   = pos.col - 4'd5;
    assign col_m1   = pos.col - 4'd1;
    assign press    = (events.velocity != '0);

    assign is_step = (events.pad_index > 7'd10) && (events.pad_index < 7'd90)
                     && (pos.col >= 4'd5) && (pos.col <= 4'd8);
    assign is_live = (events.pad_index > 7'd50) && (events.pad_index < 7'd90)
                     && (pos.col >= 4'd1) && (pos.col <= 4'd4);
    assign is_chan = (events.pad_index > 7'd10) && (events.pad_index < 7'd50)
                     && (pos.col >= 4'd1) && (pos.col <= 4'd4);

    // ---------------- row lanes ----------------
    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            lane_nz[c] = (mem_rd_data[c] != '0);
        end
    end

    assign scan_vel = mem_rd_data[scan_ch_reg];
    assign sel_vel  = mem_rd_data[sel_ch_reg];
    assign nz_above = lane_nz >> ({1'b0, scan_ch_reg} + 5'd1);

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next      = state_reg;
        tick_count_next = tick_count_reg;
        play_pos_next   = play_pos_reg;
        sel_ch_next     = sel_ch_reg;
        step_next       = step_reg;
        vel_next        = vel_reg;
        live_note_next  = live_note_reg;
        quant_mode_next = quant_mode_reg;
        scan_ch_next    = scan_ch_reg;
        sweep_cnt_next  = sweep_cnt_reg;

        mem_rd_en   = 1'b0;
        mem_rd_addr = play_pos_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = step_reg;
        mem_wr_data = mem_rd_data;

        out_load               = 1'b0;
        out_beat.note          = NOTE_W'({3'b000, scan_ch_reg}) + offset_clamped;
        out_beat.note_velocity = scan_vel;
        out_beat.live          = 1'b0;
        out_beat.last          = (nz_above == '0);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    vel_next = events.velocity;
                    if (events.command == CMD_TICK)
                    begin
                        if (tick_fire)
                        begin
                            tick_count_next = '0;
                            play_pos_next   = play_pos_reg + 1'b1;
                            state_next      = ST_TICK_RD;
                        end
                        else
                            tick_count_next = tick_inc;
                    end
                    else if (press)
                    begin
                        // Pad ranges win over the buttons, quantize over delete.
                        priority if (is_step)
                        begin
                            step_next  = {row_inv8[2:0], col_m5[1:0]};
                            state_next = ST_STEP_RD;
                        end
                        else if (is_live)
                        begin
                            live_note_next = LIVE_BASE
                                + NOTE_W'({row_inv8[1:0], col_m1[1:0]});
                            state_next     = ST_LIVE;
                        end
                        else if (is_chan)
                            sel_ch_next = {row_inv4[1:0], col_m1[1:0]};
                        else if (events.pad_index == quant_btn_reg)
                        begin
                            quant_mode_next = 1'b1;
                            sweep_cnt_next  = '0;
                            state_next      = ST_SWEEP;
                        end
                        else if (events.pad_index == del_btn_reg)
                        begin
                            quant_mode_next = 1'b0;
                            sweep_cnt_next  = '0;
                            state_next      = ST_SWEEP;
                        end
                        else
                        begin
                            // Any other pad press is ignored.
                        end
                    end
                end
            end

            ST_TICK_RD:
            begin
                mem_rd_en    = 1'b1;
                mem_rd_addr  = play_pos_reg;
                scan_ch_next = '0;
                state_next   = ST_TICK_SCAN;
            end

            ST_TICK_SCAN:
            begin
                // A silent channel is skipped; a sounding one waits for the slot.
                if (!lane_nz[scan_ch_reg] || out_free)
                begin
                    out_load = lane_nz[scan_ch_reg];
                    if (scan_ch_reg == CH_W'(CHANNELS - 1))
                        state_next = ST_IDLE;
                    else
                        scan_ch_next = scan_ch_reg + 1'b1;
                end
            end

            ST_STEP_RD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = step_reg;
                state_next  = ST_STEP_WR;
            end

            ST_STEP_WR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = step_reg;
                mem_wr_data[sel_ch_reg] = (sel_vel != '0) ? '0 : vel_reg;
                state_next  = ST_IDLE;
            end

            ST_LIVE:
            begin
                out_beat.note          = live_note_reg;
                out_beat.note_velocity = vel_reg;
                out_beat.live          = 1'b1;
                out_beat.last          = 1'b1;
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_SWEEP:
            begin
                // Row n is read while row n-1, read the cycle before, is written.
                mem_rd_en   = !sweep_cnt_reg[STEP_W];
                mem_rd_addr = sweep_cnt_reg[STEP_W-1:0];
                mem_wr_en   = (sweep_cnt_reg != '0);
                mem_wr_addr = STEP_W'(sweep_cnt_reg - 1'b1);
                if (quant_mode_reg && (sel_vel != '0))
                    mem_wr_data[sel_ch_reg] = QUANT_LEVEL;
                else
                    mem_wr_data[sel_ch_reg] = '0;
                if (sweep_cnt_reg[STEP_W])
                    state_next = ST_IDLE;
                else
                    sweep_cnt_next = sweep_cnt_reg + 1'b1;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            tick_count_reg <= TICK_COUNT_RST;
            play_pos_reg   <= '0;
            sel_ch_reg     <= '0;
            scan_ch_reg    <= '0;
            sweep_cnt_reg  <= '0;
            quant_mode_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            tick_count_reg <= tick_count_next;
            play_pos_reg   <= play_pos_next;
            sel_ch_reg     <= sel_ch_next;
            scan_ch_reg    <= scan_ch_next;
            sweep_cnt_reg  <= sweep_cnt_next;
            quant_mode_reg <= quant_mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg      <= step_next;
        vel_reg       <= vel_next;
        live_note_reg <= live_note_next;
    end

    // ---------------- submodules ----------------
    dss_pattern_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    dss_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .beat      (out_beat),
        .slot_free (out_free),
        .notes     (notes)
    );

    // ---------------- assertions ----------------
    `DSS_ASSERT_NOW(a_load_into_free_slot, out_load,
        out_free && ((state_reg == ST_TICK_SCAN) || (state_reg == ST_LIVE)))
    `DSS_ASSERT_NOW(a_write_only_in_rmw, mem_wr_en,
        (state_reg == ST_STEP_WR) || (state_reg == ST_SWEEP))
    `DSS_ASSERT_NOW(a_no_same_row_rw, mem_wr_en && mem_rd_en, mem_wr_addr != mem_rd_addr)
    `DSS_ASSERT_NOW(a_sweep_bound, state_reg == ST_SWEEP, sweep_cnt_reg <= (STEP_W + 1)'(STEPS))
    `DSS_ASSERT_NEXT(a_fire_reads_row,
        accept && (events.command == CMD_TICK) && tick_fire,
        (state_reg == ST_TICK_RD) && (tick_count_reg == '0))

endmodule

### tb/dss_note_checker.sv
// Note checker for the drum step sequencer: tracks the pattern, selection, play
// position and registers from the observed beats and compares every note beat.
// Depends on dss_pkg and the channel interfaces in dss_ifs.
module dss_note_checker (
    input  logic clk,
    input  logic rst_n,
    dss_cfg_if   cfg,
    dss_event_if events,
    dss_note_if  notes,
    output int   fails,
    output int   pending
);
    import dss_pkg::*;

    logic [VEL_W-1:0]  grid [CHANNELS][STEPS];
    logic [CH_W-1:0]   sel_ch;
    logic [STEP_W-1:0] position;
    logic [7:0]        tick_cnt;
    logic [7:0]        period;
    logic [6:0]        offset;
    logic [PAD_W-1:0]  quant_pad;
    logic [PAD_W-1:0]  clear_pad;
    note_beat_t        due_notes[$];

    task automatic step_tick();
        logic [NOTE_W-1:0] eff;
        note_beat_t        nb;
        int                last_ch;
        tick_cnt = tick_cnt + 8'd1;
        if (tick_cnt >= period)
        begin
            tick_cnt = 8'd0;
            position = position + 1'b1;
            eff = (offset > OFFSET_MAX) ? OFFSET_MAX : offset;
            last_ch = -1;
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                if (grid[ch][position] != '0)
                    last_ch = ch;
            end
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                if (grid[ch][position] != '0)
                begin
                    nb.note          = NOTE_W'(ch) + eff;
                    nb.note_velocity = grid[ch][position];
                    nb.live          = 1'b0;
                    nb.last          = (ch == last_ch);
                    due_notes.push_back(nb);
                end
            end
        end
    endtask

    task automatic press_pad(input logic [PAD_W-1:0] pad, input logic [VEL_W-1:0] vel);
        int         p;
        int         row;
        int         col;
        int         st;
        note_beat_t nb;
        p   = int'(pad);
        row = p / 10;
        col = p % 10;
        // The pad ranges are tested first, so a button placed on a pad acts as that pad.
        if (p > 10 && p < 90 && col >= 5 && col <= 8)
        begin
            if (vel != '0)
            begin
                st = (8 - row) * 4 + (col - 5);
                grid[sel_ch][st] = (grid[sel_ch][st] != '0) ? '0 : vel;
            end
        end
        else if (p > 50 && p < 90 && col >= 1 && col <= 4)
        begin
            if (vel != '0)
            begin
                nb.note          = LIVE_BASE + NOTE_W'((8 - row) * 4 + (col - 1));
                nb.note_velocity = vel;
                nb.live          = 1'b1;
                nb.last          = 1'b1;
                due_notes.push_back(nb);
            end
        end
        else if (p > 10 && p < 50 && col >= 1 && col <= 4)
        begin
            if (vel != '0)
                sel_ch = CH_W'((4 - row) * 4 + (col - 1));
        end
        else if (pad == quant_pad && vel != '0)
        begin
            for (int s = 0; s < STEPS; s++)
            begin
                if (grid[sel_ch][s] != '0)
                    grid[sel_ch][s] = QUANT_LEVEL;
            end
        end
        else if (pad == clear_pad && vel != '0)
        begin
            for (int s = 0; s < STEPS; s++)
                grid[sel_ch][s] = '0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        note_beat_t want;
        if (!rst_n)
        begin
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                for (int s = 0; s < STEPS; s++)
                    grid[ch][s] = '0;
            end
            sel_ch    = '0;
            position  = '0;
            tick_cnt  = TICK_COUNT_RST;
            period    = TICK_PERIOD_RST;
            offset    = NOTE_OFFSET_RST;
            quant_pad = QUANT_BTN_RST;
            clear_pad = DEL_BTN_RST;
            due_notes.delete();
            fails     = 0;
            pending   = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_TICK_PERIOD: period    = cfg.data;
                    CFG_NOTE_OFFSET: offset    = cfg.data[6:0];
                    CFG_QUANT_BTN:   quant_pad = cfg.data[PAD_W-1:0];
                    CFG_DEL_BTN:     clear_pad = cfg.data[PAD_W-1:0];
                    default: ;
                endcase
            end

            // Every note of an event is queued when the event beat is taken; a note beat
            // passes a sequencer state and the output register first, so the order here is safe.
            if (notes.valid && notes.ready)
            begin
                if (due_notes.size() == 0)
                begin
                    $error("unexpected note beat: note %0d note_velocity %0d live %0d last %0d",
                           notes.note, notes.note_velocity, notes.live, notes.last);
                    fails++;
                end
                else
                begin
                    want = due_notes.pop_front();
                    if (notes.note !== want.note)
                    begin
                        $error("note: expected %0d, got %0d", want.note, notes.note);
                        fails++;
                    end
                    if (notes.note_velocity !== want.note_velocity)
                    begin
                        $error("note_velocity: expected %0d, got %0d",
                               want.note_velocity, notes.note_velocity);
                        fails++;
                    end
                    if (notes.live !== want.live)
                    begin
                        $error("live: expected %0d, got %0d", want.live, notes.live);
                        fails++;
                    end
                    if (notes.last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, notes.last);
                        fails++;
                    end
                end
            end

            if (events.valid && events.ready)
            begin
                if (events.command == CMD_TICK)
                    step_tick();
                else
                    press_pad(events.pad_index, events.velocity);
            end
            pending = due_notes.size();
        end
    end

endmodule

### tb/drum_step_sequencer_test.sv
// Top of the drum step sequencer testbench: clock, reset, event and register
// stimulus, note sink with stalls, and the verdict.
// Depends on dss_pkg, dss_ifs, the RTL and dss_note_checker.
module drum_step_sequencer_test;
    import dss_pkg::*;

    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int DRAIN_CYCLES = 64;

    logic clk = 1'b0;
    logic rst_n;
    int   fails;
    int   pending;
    int   cycle_count = 0;
    int   hold_request = 0;
    bit   tx_idle = 1'b0;
    bit   rx_idle = 1'b0;
    logic [PAD_W-1:0] quant_now = QUANT_BTN_RST;
    logic [PAD_W-1:0] clear_now = DEL_BTN_RST;

    dss_cfg_if   cfg();
    dss_event_if events();
    dss_note_if  notes();

    drum_step_sequencer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .events (events),
        .notes  (notes)
    );

    dss_note_checker note_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .events  (events),
        .notes   (notes),
        .fails   (fails),
        .pending (pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [VEL_W-1:0] pick_vel();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return '0;
        if (r < 25)
            return 7'd127;
        if (r < 30)
            return 7'd1;
        return VEL_W'($urandom_range(1, 126));
    endfunction

    function automatic logic [PAD_W-1:0] step_pad(input int s);
        return PAD_W'((8 - s / 4) * 10 + 5 + s % 4);
    endfunction

    function automatic logic [PAD_W-1:0] chan_pad(input int c);
        return PAD_W'((4 - c / 4) * 10 + 1 + c % 4);
    endfunction

    function automatic logic [PAD_W-1:0] live_pad(input int k);
        return PAD_W'((8 - k / 4) * 10 + 1 + k % 4);
    endfunction

    // Note sink: ready drops for random stretches, or for one long hold-off on request.
    initial
    begin
        int stall;
        stall = 0;
        notes.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                stall = hold_request;
                hold_request = 0;
            end
            if (stall > 0)
            begin
                notes.ready <= 1'b0;
                stall--;
            end
            else
            begin
                notes.ready <= 1'b1;
                if (rx_idle && $urandom_range(0, 3) == 0)
                    stall = pick_gap();
            end
        end
    end

    task automatic send_event(input logic cmd, input logic [PAD_W-1:0] pad,
                              input logic [VEL_W-1:0] vel);
        int gap;
        gap = tx_idle ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            events.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        events.valid     <= 1'b1;
        events.command   <= cmd;
        events.pad_index <= pad;
        events.velocity  <= vel;
        do @(posedge clk); while (!events.ready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do @(posedge clk); while (!cfg.ready);
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // Stops offering events and waits until every note has come; quantize and
    // clear leave no note behind, so the block gets time to finish its sweep.
    task automatic settle();
        @(negedge clk);
        events.valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input logic [7:0] period, input logic [6:0] offset,
                             input logic [PAD_W-1:0] qb, input logic [PAD_W-1:0] db);
        settle();
        write_reg(CFG_TICK_PERIOD, period);
        write_reg(CFG_NOTE_OFFSET, CFG_DATA_W'(offset));
        write_reg(CFG_QUANT_BTN, CFG_DATA_W'(qb));
        write_reg(CFG_DEL_BTN, CFG_DATA_W'(db));
        quant_now = qb;
        clear_now = db;
    endtask

    // Mostly well-formed play: ticks, step edits on the selected channel, channel
    // changes, live notes and buttons, with some arbitrary pad beats mixed in.
    task automatic random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            send_event(CMD_TICK, PAD_W'($urandom_range(0, 127)), VEL_W'($urandom_range(0, 127)));
        else if (r < 60)
            send_event(CMD_PAD, step_pad($urandom_range(0, STEPS - 1)), pick_vel());
        else if (r < 70)
            send_event(CMD_PAD, chan_pad($urandom_range(0, CHANNELS - 1)), pick_vel());
        else if (r < 80)
            send_event(CMD_PAD, live_pad($urandom_range(0, 15)), pick_vel());
        else if (r < 85)
            send_event(CMD_PAD, ($urandom_range(0, 1) != 0) ? quant_now : clear_now, pick_vel());
        else
            send_event(CMD_PAD, PAD_W'($urandom_range(0, 127)), VEL_W'($urandom_range(0, 127)));
    endtask

    initial
    begin
        rst_n            = 1'b0;
        events.valid     = 1'b0;
        events.command   = CMD_TICK;
        events.pad_index = '0;
        events.velocity  = '0;
        cfg.valid        = 1'b0;
        cfg.index        = CFG_TICK_PERIOD;
        cfg.data         = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, reset settings: the first tick advances at once.
        send_event(CMD_TICK, '0, '0);
        send_event(CMD_PAD, step_pad(1), 7'd127);
        send_event(CMD_PAD, step_pad(1), 7'd0);
        send_event(CMD_PAD, live_pad(15), 7'd127);
        send_event(CMD_PAD, live_pad(3), 7'd1);
        send_event(CMD_PAD, live_pad(15), 7'd0);
        send_event(CMD_PAD, 7'd0, 7'd127);
        send_event(CMD_PAD, 7'd127, 7'd127);
        send_event(CMD_PAD, 7'd10, 7'd64);
        send_event(CMD_PAD, 7'd90, 7'd64);
        send_event(CMD_PAD, 7'd99, 7'd64);
        send_event(CMD_PAD, 7'd100, 7'd64);
        send_event(CMD_PAD, QUANT_BTN_RST, 7'd64);
        send_event(CMD_PAD, 7'd49, 7'd64);

        // Zero period, offset past the clamp, both buttons on one pad.
        configure(8'd0, 7'd127, 7'd50, 7'd50);
        send_event(CMD_PAD, step_pad(2), 7'd127);
        send_event(CMD_PAD, chan_pad(15), 7'd1);
        send_event(CMD_PAD, step_pad(2), 7'd1);
        send_event(CMD_TICK, '0, '0);
        send_event(CMD_PAD, chan_pad(0), 7'd9);
        send_event(CMD_PAD, 7'd50, 7'd5);

        // A button placed on a step pad loses to the step.
        configure(8'd1, 7'd0, step_pad(1), 7'd99);
        send_event(CMD_PAD, step_pad(1), 7'd20);
        send_event(CMD_PAD, 7'd99, 7'd127);
        send_event(CMD_TICK, '0, '0);

        // Fill one step on all channels, then hold the sink off while ticks pile up.
        // Forty ticks at a zero period pass the filled step at least once.
        configure(8'd0, 7'd36, 7'd127, 7'd0);
        rx_idle = 1'b1;
        tx_idle = 1'b1;
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            send_event(CMD_PAD, chan_pad(ch), 7'd100);
            send_event(CMD_PAD, 7'd0, 7'd1);
            send_event(CMD_PAD, step_pad(5), VEL_W'($urandom_range(1, 127)));
        end
        tx_idle = 1'b0;
        hold_request = 300;
        repeat (40) send_event(CMD_TICK, '0, '0);

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: configure(8'd1, 7'd0, 7'd0, 7'd127);
                1: configure(8'd2, 7'd112, 7'd95, 7'd59);
                2: configure(8'd0, 7'($urandom_range(113, 127)), 7'd120, 7'd120);
                3: configure(8'($urandom_range(1, 4)), 7'($urandom_range(0, 127)),
                             7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
                default: configure(8'd255, 7'd100, 7'($urandom_range(0, 127)),
                                   7'($urandom_range(0, 127)));
            endcase
            tx_idle = $urandom_range(0, 2) != 0;
            rx_idle = $urandom_range(0, 2) != 0;
            for (int i = 0; i < 8; i++)
            begin
                random_item();
                // Mid-phase, let every outstanding note drain before going on.
                if (ph == 2 && i == 3)
                    settle();
            end
        end

        settle();
        if (fails == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
